/* rtl/mse_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the MIPS-subset execute unit: instruction codes,
// register addresses, field widths and default sizes. No dependencies.
package mse_pkg;

  // Default sizes of the state stores
  localparam int DATA_WORDS_DEF = 32;
  localparam int REG_COUNT_DEF  = 32;

  // Stream and configuration port widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 96;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Field widths
  localparam int MODE_W = 5;
  localparam int RIDX_FIELD_W = 5;
  localparam int IMM_W = 10;
  localparam int PC_W = 16;
  localparam int WORD_W = 32;

  // Instruction codes
  localparam logic [MODE_W-1:0] MODE_NOP   = 5'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 5'd1;
  localparam logic [MODE_W-1:0] MODE_SUB   = 5'd2;
  localparam logic [MODE_W-1:0] MODE_MUL   = 5'd3;
  localparam logic [MODE_W-1:0] MODE_AND   = 5'd4;
  localparam logic [MODE_W-1:0] MODE_NOR   = 5'd5;
  localparam logic [MODE_W-1:0] MODE_SLT   = 5'd6;
  localparam logic [MODE_W-1:0] MODE_SLL   = 5'd7;
  localparam logic [MODE_W-1:0] MODE_SRL   = 5'd8;
  localparam logic [MODE_W-1:0] MODE_SRA   = 5'd9;
  localparam logic [MODE_W-1:0] MODE_BEQ   = 5'd10;
  localparam logic [MODE_W-1:0] MODE_BGTZ  = 5'd11;
  localparam logic [MODE_W-1:0] MODE_BLTZ  = 5'd12;
  localparam logic [MODE_W-1:0] MODE_SW    = 5'd13;
  localparam logic [MODE_W-1:0] MODE_LW    = 5'd14;
  localparam logic [MODE_W-1:0] MODE_J     = 5'd15;
  localparam logic [MODE_W-1:0] MODE_JR    = 5'd16;
  localparam logic [MODE_W-1:0] MODE_BREAK = 5'd17;

  // Configuration registers, selected by the word address bit
  localparam logic REG_START_ADDRESS = 1'b0;
  localparam logic REG_DATA_BASE     = 1'b1;

  localparam logic [PC_W-1:0] START_ADDRESS_RST = 16'd64;
  localparam logic [PC_W-1:0] DATA_BASE_RST     = 16'd148;

endpackage

/* rtl/mips_subset_execute_unit_top.sv */
`timescale 1ns / 1ps
// Execute unit for a small MIPS-like instruction set: register file, data
// memory, program counter, ALU and stream/APB ports. Depends on mse_pkg.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+---------------------------------
//  s_*      | in        | s_tvalid / s_tready | one decoded instruction request
//  m_*      | out       | m_tvalid / m_tready | effects of one instruction
//  APB      | in        | psel/penable/pready | start_address, data_base
//
//  Throughput is one instruction a cycle when neither m_tready nor the memory
//  clear stalls; the accepting edge loads the input register, and the result
//  register, which drives m_tvalid, is loaded from it in turn. A load result is forwarded
//  straight from the data memory's read register, so back-to-back dependent
//  instructions never wait.
//  After reset the data memory is cleared one word a cycle, through all
//  DATA_WORDS words, with s_tready held low; APB writes are taken throughout.
//  A stall on m_tready holds the result register and, once the input
//  register is full too, drops s_tready.
module mips_subset_execute_unit_top #(
  parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEF,
  parameter int REG_COUNT  = mse_pkg::REG_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // instruction requests
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [4:0] dest_reg, [9:5] src_a_reg, [14:10] src_b_reg, [15] use_immediate,
  // [25:16] immediate, [31:26] zero
  input  logic [mse_pkg::IN_DATA_W-1:0]  s_tdata,
  // [4:0] mode
  input  logic [mse_pkg::IN_USER_W-1:0]  s_tuser,
  // results
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] next_pc, [16] reg_written, [21:17] reg_index, [53:22] reg_value,
  // [54] mem_written, [59:55] mem_index, [91:60] mem_value, [92] halted,
  // [93] addr_error, [95:94] zero
  output logic [mse_pkg::OUT_DATA_W-1:0] m_tdata,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mse_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mse_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mse_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mse_pkg::*;

  localparam int RIDX_W = $clog2(REG_COUNT);
  localparam int DIDX_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  // Per-operand read qualifiers captured with the registered read
  typedef struct packed {
    logic bad;  // register zero or beyond the file: reads as zero
    logic wt;   // written at the very edge of the read: take the write data
    logic vld;  // entry written since reset
  } opflag_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PC_W-1:0] start_address;
  logic [PC_W-1:0] data_base;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_DATA_BASE) ? {16'b0, data_base} : {16'b0, start_address};

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic x_valid, w_valid;
  logic w_free, x_move, s_accept, commit;
  logic clr_busy;
  logic [DIDX_W-1:0] clr_cnt;

  assign w_free   = !w_valid || m_tready;
  assign x_move   = x_valid && w_free;
  assign s_tready = !clr_busy && (!x_valid || w_free);
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = w_valid;

  // ---------------------------------------------------------------------------
  // Request fields
  // ---------------------------------------------------------------------------
  logic [RIDX_FIELD_W-1:0] in_dest, in_srca, in_srcb;

  assign in_dest = s_tdata[4:0];
  assign in_srca = s_tdata[9:5];
  assign in_srcb = s_tdata[14:10];

  // ---------------------------------------------------------------------------
  // Register file: two copies so that each has at most two read ports.
  // Copy A serves both sources, copy D the destination-field operand.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] rf_a [REG_COUNT];
  logic [WORD_W-1:0] rf_d [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld;

  logic                    w_wreg;
  logic [RIDX_FIELD_W-1:0] w_idx;
  logic [WORD_W-1:0]       w_val;

  assign commit = w_valid && m_tready && w_wreg;

  function automatic opflag_t read_flags(
    input logic [RIDX_FIELD_W-1:0] idx,
    input logic                    wr_en,
    input logic [RIDX_FIELD_W-1:0] wr_idx,
    input logic [REG_COUNT-1:0]    vld_vec
  );
    opflag_t f;
    f.bad = (idx == '0) || (32'(idx) >= 32'(REG_COUNT));
    f.wt  = wr_en && (wr_idx == idx);
    f.vld = f.bad ? 1'b0 : vld_vec[idx[RIDX_W-1:0]];
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Input register (X)
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]       x_mode;
  logic [RIDX_FIELD_W-1:0] x_dest, x_srca, x_srcb;
  logic                    x_useimm;
  logic [IMM_W-1:0]        x_imm;
  logic [WORD_W-1:0]       x_a_raw, x_b_raw, x_d_raw, x_wt_val;
  opflag_t                 x_fa, x_fb, x_fd;

  always_ff @(posedge clk) begin
    if (s_accept) begin
      x_mode   <= s_tuser;
      x_dest   <= in_dest;
      x_srca   <= in_srca;
      x_srcb   <= in_srcb;
      x_useimm <= s_tdata[15];
      x_imm    <= s_tdata[25:16];
      x_a_raw  <= rf_a[in_srca[RIDX_W-1:0]];
      x_b_raw  <= rf_a[in_srcb[RIDX_W-1:0]];
      x_d_raw  <= rf_d[in_dest[RIDX_W-1:0]];
      x_wt_val <= w_val;
      x_fa     <= read_flags(in_srca, commit, w_idx, rf_vld);
      x_fb     <= read_flags(in_srcb, commit, w_idx, rf_vld);
      x_fd     <= read_flags(in_dest, commit, w_idx, rf_vld);
    end
    if (commit) begin
      rf_a[w_idx[RIDX_W-1:0]] <= w_val;
      rf_d[w_idx[RIDX_W-1:0]] <= w_val;
    end
  end

  // Resolve an operand: the result register holds the only older write not
  // yet in the file, so it wins; then the write-through, then the file.
  function automatic logic [WORD_W-1:0] resolve(
    input opflag_t                 f,
    input logic [WORD_W-1:0]       raw,
    input logic [WORD_W-1:0]       wt_val,
    input logic [RIDX_FIELD_W-1:0] idx,
    input logic                    fwd_en,
    input logic [RIDX_FIELD_W-1:0] fwd_idx,
    input logic [WORD_W-1:0]       fwd_val
  );
    logic [WORD_W-1:0] v;
    if (f.bad)                           v = '0;
    else if (fwd_en && fwd_idx == idx)   v = fwd_val;
    else if (f.wt)                       v = wt_val;
    else if (f.vld)                      v = raw;
    else                                 v = '0;
    return v;
  endfunction

  logic [WORD_W-1:0] ra, rb_reg, rb, rdv;
  logic              fwd_en;

  assign fwd_en = w_valid && w_wreg;
  assign ra     = resolve(x_fa, x_a_raw, x_wt_val, x_srca, fwd_en, w_idx, w_val);
  assign rb_reg = resolve(x_fb, x_b_raw, x_wt_val, x_srcb, fwd_en, w_idx, w_val);
  assign rdv    = resolve(x_fd, x_d_raw, x_wt_val, x_dest, fwd_en, w_idx, w_val);
  assign rb     = x_useimm ? {22'b0, x_imm} : rb_reg;

  // ---------------------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------------------
  logic [PC_W-1:0]   pc, pc_base, pc_next;
  logic [4:0]        sh;
  logic [WORD_W-1:0] alu_val, addr, off;
  logic [29:0]       word;
  logic              alu_op, seq, halt, is_sw, is_lw, in_range, dest_ok;
  logic              x_wreg, x_wmem, x_aerr;
  logic [DIDX_W-1:0] didx;

  assign sh       = rb[4:0];
  assign addr     = ra + {22'b0, x_imm};
  assign off      = addr - {16'b0, data_base};
  assign word     = off[31:2];
  assign in_range = (addr >= {16'b0, data_base}) && (32'(word) < 32'(DATA_WORDS));
  assign didx     = word[DIDX_W-1:0];
  assign dest_ok  = (x_dest != '0) && (32'(x_dest) < 32'(REG_COUNT));

  always_comb begin
    alu_val = '0;
    alu_op  = 1'b0;
    pc_base = pc;
    seq     = 1'b1;
    halt    = 1'b0;
    is_sw   = 1'b0;
    is_lw   = 1'b0;
    unique case (x_mode)
      MODE_ADD: begin alu_val = ra + rb;  alu_op = 1'b1; end
      MODE_SUB: begin alu_val = ra - rb;  alu_op = 1'b1; end
      MODE_MUL: begin alu_val = ra * rb;  alu_op = 1'b1; end
      MODE_AND: begin alu_val = ra & rb;  alu_op = 1'b1; end
      MODE_NOR: begin alu_val = ~(ra | rb); alu_op = 1'b1; end
      MODE_SLT: begin
        alu_val = {31'b0, $signed(ra) < $signed(rb)};
        alu_op  = 1'b1;
      end
      MODE_SLL: begin alu_val = ra << sh; alu_op = 1'b1; end
      MODE_SRL: begin alu_val = ra >> sh; alu_op = 1'b1; end
      MODE_SRA: begin alu_val = WORD_W'($signed(ra) >>> sh); alu_op = 1'b1; end
      MODE_BEQ: begin
        if (rdv == ra) pc_base = pc + PC_W'(x_imm);
      end
      MODE_BGTZ: begin
        if (!rdv[31] && rdv != '0) pc_base = pc + PC_W'(x_imm);
      end
      MODE_BLTZ: begin
        if (rdv[31]) pc_base = pc + PC_W'(x_imm);
      end
      MODE_SW: is_sw = 1'b1;
      MODE_LW: is_lw = 1'b1;
      MODE_J: begin
        pc_base = PC_W'(x_imm);
        seq     = 1'b0;
      end
      MODE_JR: begin
        pc_base = rdv[PC_W-1:0];
        seq     = 1'b0;
      end
      MODE_BREAK: begin
        pc_base = '0;
        seq     = 1'b0;
        halt    = 1'b1;
      end
      default: ;  // NOP and unused codes
    endcase
  end

  assign pc_next = seq ? pc_base + 16'd4 : pc_base;
  assign x_wreg  = dest_ok && (alu_op || (is_lw && in_range));
  assign x_wmem  = is_sw && in_range;
  assign x_aerr  = (is_sw || is_lw) && !in_range;

  // ---------------------------------------------------------------------------
  // Data memory: written by stores or by the clearing pass, read for loads
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] dmem [DATA_WORDS];
  logic [WORD_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      dmem[clr_cnt] <= '0;
    end else if (x_move && x_wmem) begin
      dmem[didx] <= rdv;
    end
    if (x_move) begin
      mem_rdata <= dmem[didx];
    end
  end

  // ---------------------------------------------------------------------------
  // Result register (W)
  // ---------------------------------------------------------------------------
  logic [PC_W-1:0]   w_next_pc;
  logic [WORD_W-1:0] w_alu_val, w_mval;
  logic              w_is_lw, w_wmem, w_halt, w_aerr;
  logic [4:0]        w_midx;

  always_ff @(posedge clk) begin
    if (x_move) begin
      w_next_pc <= pc_next;
      w_wreg    <= x_wreg;
      w_idx     <= x_wreg ? x_dest : '0;
      w_alu_val <= (x_wreg && alu_op) ? alu_val : '0;
      w_is_lw   <= x_wreg && is_lw;
      w_wmem    <= x_wmem;
      w_midx    <= x_wmem ? word[4:0] : '0;
      w_mval    <= x_wmem ? rdv : '0;
      w_halt    <= halt;
      w_aerr    <= x_aerr;
    end
  end

  assign w_val = w_is_lw ? mem_rdata : w_alu_val;

  assign m_tdata = {2'b0, w_aerr, w_halt, w_mval, w_midx, w_wmem,
                    w_val, w_idx, w_wreg, w_next_pc};

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid       <= 1'b0;
      w_valid       <= 1'b0;
      rf_vld        <= '0;
      clr_busy      <= 1'b1;
      clr_cnt       <= '0;
      start_address <= START_ADDRESS_RST;
      data_base     <= DATA_BASE_RST;
      pc            <= START_ADDRESS_RST;
    end else begin
      // advance the two stages
      if (s_accept)    x_valid <= 1'b1;
      else if (x_move) x_valid <= 1'b0;
      if (x_move)      w_valid <= 1'b1;
      else if (m_tready) w_valid <= 1'b0;

      if (commit) rf_vld[w_idx[RIDX_W-1:0]] <= 1'b1;

      // sweep the data memory once after reset
      if (clr_busy) begin
        if (clr_cnt == DIDX_W'(DATA_WORDS - 1)) clr_busy <= 1'b0;
        else                                     clr_cnt  <= clr_cnt + DIDX_W'(1);
      end

      // a new start address also reloads the program counter
      if (cfg_wr && paddr[2] == REG_START_ADDRESS) begin
        start_address <= pwdata[PC_W-1:0];
        pc            <= pwdata[PC_W-1:0];
      end else if (x_move) begin
        pc <= pc_next;
      end
      if (cfg_wr && paddr[2] == REG_DATA_BASE) begin
        data_base <= pwdata[PC_W-1:0];
      end
    end
  end

endmodule
